// ===== rtl/core/phcdf_pkg.sv =====
// shared constants, request codes and payload types of the pixel histogram block
package phcdf_pkg;

  localparam int NUM_BINS   = 256;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int PIX_W      = 8;
  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_W     = FRAC_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [FRAC_W-1:0]     FRAC_ONE  = FRAC_W'(1) << FRAC_BITS;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // channel select codes
  localparam logic [1:0] CHAN_1 = 2'd1;
  localparam logic [1:0] CHAN_2 = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [PIX_W-1:0] chan0;
    logic [PIX_W-1:0] chan1;
    logic [PIX_W-1:0] chan2;
    logic [7:0]       query_bin;
  } in_req_t;

  typedef struct packed {
    logic [7:0]            bin_index;
    logic [23:0]           bin_count;
    logic [23:0]           cumulative_count;
    logic [16:0]           cdf_fraction;
    logic                  empty_flag;
    logic                  overflow_flag;
  } out_rsp_t;

  // values at or above the bin count land in the last bin
  function automatic logic [BIN_W-1:0] clamp_bin(input logic [7:0] v);
    logic [BIN_W-1:0] b;
    if (32'(v) >= NUM_BINS) begin
      b = BIN_W'(NUM_BINS - 1);
    end else begin
      b = v[BIN_W-1:0];
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/phcdf_div.sv =====
// restoring divider that forms the 1.16 cdf fraction, one quotient bit per cycle
module phcdf_div (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [phcdf_pkg::COUNT_BITS-1:0]         dividend_i,
  input  logic [phcdf_pkg::COUNT_BITS-1:0]         divisor_i,
  output logic                                     done_o,
  output logic [phcdf_pkg::FRAC_W-1:0]             frac_o
);

  localparam int CW = phcdf_pkg::COUNT_BITS;
  localparam int NW = $clog2(phcdf_pkg::FRAC_BITS + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] dvs_q, dvs_d;
  logic [phcdf_pkg::FRAC_W-1:0] quo_q, quo_d;
  logic [CW:0]   rem_sh;
  logic [CW:0]   rem_sub;
  logic          take;

  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign take    = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      dvs_d = divisor_i;
      rem_d = dividend_i;
      quo_d = '0;
      cnt_d = NW'(phcdf_pkg::FRAC_BITS);
      if (dividend_i >= divisor_i) begin
        // ratio of one or more caps at 1.0
        quo_d  = phcdf_pkg::FRAC_ONE;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = take ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      quo_d = {quo_q[phcdf_pkg::FRAC_W-2:0], take};
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign frac_o = quo_q;

endmodule

// ===== rtl/core/pixel_histogram_cdf.sv =====
// top level: 256-bin pixel histogram with cumulative distribution query
//
// Requests arrive on the in channel (in_valid_i / in_ready_o) as one in_req_t.
// A clear request empties the histogram, an add request counts the selected
// channel of one pixel (bin read, then write back through the store's write
// port). A query walks bins 0 to the requested bin, one store read per cycle,
// then a 16-step divider forms the fraction; when the histogram is empty or
// the fraction is a full 1.0, the divider skips its steps and is done at once.
// Only queries produce a response, on the out channel (out_valid_o /
// out_ready_i) as one out_rsp_t. The response sits in an output register, so
// clear and add requests keep flowing while it waits; a further query holds
// in its final state until the register is free.
// channel_select is written over the cfg channel, which is always ready, and
// should only be written while no request is in flight.
// Reset clears the per-bin valid bits, the pixel total and the overflow flag,
// so the histogram is empty at once with no clearing pass.
module pixel_histogram_cdf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  phcdf_pkg::in_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output phcdf_pkg::out_rsp_t out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_data_i
);

  localparam int NB = phcdf_pkg::NUM_BINS;
  localparam int BW = phcdf_pkg::BIN_W;
  localparam int CW = phcdf_pkg::COUNT_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD_WR = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [1:0]    chsel_q;
  logic [CW-1:0] total_q, total_d;
  logic          sat_q, sat_d;
  logic [BW-1:0] bin_q, bin_d;
  logic [BW-1:0] idx_q, idx_d;
  logic [BW-1:0] qbin_q, qbin_d;
  logic [CW-1:0] cum_q, cum_d;
  logic [CW-1:0] bcnt_q, bcnt_d;

  logic [CW-1:0] mem_q [NB];
  logic [NB-1:0] vld_q;
  logic [CW-1:0] rd_data_q;
  logic          rd_vld_q;
  logic [BW-1:0] rd_addr;
  logic          mem_we;
  logic [BW-1:0] wr_addr;
  logic [CW-1:0] wr_data;
  logic          vld_clr;
  logic [CW-1:0] cnt;

  logic          out_valid_q;
  phcdf_pkg::out_rsp_t out_q;
  logic          out_load;

  logic          in_acc;
  logic [7:0]    pix;
  logic [CW:0]   cum_sum;
  logic          div_start;
  logic          div_done;
  logic [phcdf_pkg::FRAC_W-1:0] div_frac;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // a bin never written since the last clear reads as zero
  assign cnt = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    case (chsel_q)
      phcdf_pkg::CHAN_1: pix = in_req_i.chan1;
      phcdf_pkg::CHAN_2: pix = in_req_i.chan2;
      default:           pix = in_req_i.chan0;
    endcase
  end

  assign cum_sum = {1'b0, cum_q} + {1'b0, cnt};

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    sat_d     = sat_q;
    bin_d     = bin_q;
    idx_d     = idx_q;
    qbin_d    = qbin_q;
    cum_d     = cum_q;
    bcnt_d    = bcnt_q;
    rd_addr   = idx_q;
    mem_we    = 1'b0;
    wr_addr   = bin_q;
    wr_data   = cnt + CW'(1);
    vld_clr   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rd_addr = phcdf_pkg::clamp_bin(pix);
        if (in_acc) begin
          case (in_req_i.req_type)
            phcdf_pkg::REQ_CLEAR: begin
              vld_clr = 1'b1;
              total_d = '0;
              sat_d   = 1'b0;
            end
            phcdf_pkg::REQ_ADD: begin
              bin_d   = phcdf_pkg::clamp_bin(pix);
              state_d = ST_ADD_WR;
            end
            phcdf_pkg::REQ_QUERY: begin
              rd_addr = '0;
              idx_d   = '0;
              qbin_d  = phcdf_pkg::clamp_bin(in_req_i.query_bin);
              cum_d   = '0;
              state_d = ST_WALK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_WR: begin
        if (cnt != phcdf_pkg::COUNT_MAX) begin
          mem_we = 1'b1;
        end else begin
          sat_d = 1'b1;
        end
        if (total_q != phcdf_pkg::COUNT_MAX) begin
          total_d = total_q + CW'(1);
        end else begin
          sat_d = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        // read of bin idx_q lands now; next read goes out in the same cycle
        cum_d   = cum_sum[CW] ? phcdf_pkg::COUNT_MAX : cum_sum[CW-1:0];
        rd_addr = idx_q + BW'(1);
        if (idx_q == qbin_q) begin
          bcnt_d    = cnt;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          idx_d = idx_q + BW'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  phcdf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cum_d),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .frac_o     (div_frac)
  );

  // bin store, one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (vld_clr) begin
        vld_q <= '0;
      end else if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chsel_q     <= '0;
      total_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      sat_q   <= sat_d;
      if (cfg_valid_i) begin
        chsel_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    idx_q  <= idx_d;
    qbin_q <= qbin_d;
    cum_q  <= cum_d;
    bcnt_q <= bcnt_d;
    if (out_load) begin
      out_q.bin_index        <= 8'(qbin_q);
      out_q.bin_count        <= 24'(bcnt_q);
      out_q.cumulative_count <= 24'(cum_q);
      out_q.cdf_fraction     <= (total_q == '0) ? 17'd0 : 17'(div_frac);
      out_q.empty_flag       <= (total_q == '0);
      out_q.overflow_flag    <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
